// ----- design/pml_pkg.sv -----
package pml_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned SpeedW = 32;

  typedef enum logic [4:0] {
    ST_CLEARING     = 5'd1,
    ST_STOPPED      = 5'd2,
    ST_STARTING     = 5'd3,
    ST_IDLE         = 5'd4,
    ST_SUSPENDED    = 5'd5,
    ST_EXECUTE      = 5'd6,
    ST_STOPPING     = 5'd7,
    ST_ABORTING     = 5'd8,
    ST_ABORTED      = 5'd9,
    ST_HOLDING      = 5'd10,
    ST_HELD         = 5'd11,
    ST_UNHOLDING    = 5'd12,
    ST_SUSPENDING   = 5'd13,
    ST_UNSUSPENDING = 5'd14,
    ST_RESETTING    = 5'd15,
    ST_COMPLETING   = 5'd16,
    ST_COMPLETE     = 5'd17
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_RESET     = 4'd1,
    CMD_START     = 4'd2,
    CMD_STOP      = 4'd3,
    CMD_HOLD      = 4'd4,
    CMD_UNHOLD    = 4'd5,
    CMD_SUSPEND   = 4'd6,
    CMD_UNSUSPEND = 4'd7,
    CMD_ABORT     = 4'd8,
    CMD_CLEAR     = 4'd9
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_COMMAND    = 3'd0,
    KIND_STATE_DONE = 3'd1,
    KIND_EXEC_DONE  = 3'd2,
    KIND_COUNT      = 3'd3,
    KIND_SET_MODE   = 3'd4,
    KIND_TICK       = 3'd5
  } kind_e;

  localparam logic [3:0] UnitModeReset = 4'd1;

  function automatic logic is_acting_f(state_e s);
    logic r;
    unique case (s) inside
      ST_CLEARING, ST_STARTING, ST_STOPPING, ST_ABORTING, ST_HOLDING,
      ST_UNHOLDING, ST_SUSPENDING, ST_UNSUSPENDING, ST_RESETTING,
      ST_COMPLETING: r = 1'b1;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/pml_in_if.sv -----
interface pml_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [3:0] command;
  logic       defective;
  logic [3:0] new_unit_mode;

  modport source (output valid, output mode, output command, output defective,
                  output new_unit_mode, input ready);
  modport sink (input valid, input mode, input command, input defective,
                input new_unit_mode, output ready);
endinterface

// ----- design/pml_out_if.sv -----
interface pml_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [4:0]         cur_state;
  logic               is_acting;
  logic [3:0]         cur_unit_mode;
  logic signed [31:0] speed_actual;
  logic [31:0]        state_time_ms;
  logic [31:0]        run_time_ms;
  logic [31:0]        units_processed;
  logic [31:0]        units_defective;

  modport source (output valid, output accepted, output cur_state,
                  output is_acting, output cur_unit_mode, output speed_actual,
                  output state_time_ms, output run_time_ms, output units_processed,
                  output units_defective, input ready);
  modport sink (input valid, input accepted, input cur_state,
                input is_acting, input cur_unit_mode, input speed_actual,
                input state_time_ms, input run_time_ms, input units_processed,
                input units_defective, output ready);
endinterface

// ----- design/packml_state_model_top.sv -----
// PackML machine state model with TR88 state numbering.
// in_i carries one event word per handshake: a command, state complete,
// execute complete, a counted unit, a unit mode request or a 1 ms tick.
// out_o returns one status word per event, showing the state, unit mode,
// actual speed, times and unit counters after that event.
// speed_command_i is loaded whenever speed_command_we_i is high; write it
// only while no event is in flight.
// The status word is valid in the cycle after its event is taken.
// Throughput: one event per cycle unless out_o stalls; the state and counter
// update is a single level of next-state logic ahead of state and status regs.
// in_i.ready is high while the status register is empty or being read, so
// a stalled receiver holds one status word and stops the input after it.
// Reset: state Stopped, unit mode 1 (producing), counters, times and the
// commanded speed cleared, no status word pending.
module packml_state_model_top
  import pml_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     speed_command_we_i,
  input  logic signed [SpeedW-1:0] speed_command_i,
  pml_in_if.sink                   in_i,
  pml_out_if.source                out_o
);

  logic signed [SpeedW-1:0] speed_q;
  state_e                   state_q, state_d;
  logic [3:0]               umode_q, umode_d;
  logic [CountW-1:0]        proc_q, proc_d;
  logic [CountW-1:0]        defect_q, defect_d;
  logic [CountW-1:0]        tis_q, tis_d;
  logic [CountW-1:0]        tsr_q, tsr_d;
  logic                     acc_d;
  state_e                   cmd_next;
  state_e                   done_next;
  logic                     abort_branch;
  logic                     in_take;
  logic                     out_valid_q;

  logic                     o_acc_q;
  state_e                   o_state_q;
  logic                     o_acting_q;
  logic [3:0]               o_umode_q;
  logic signed [SpeedW-1:0] o_speed_q;
  logic [CountW-1:0]        o_tis_q, o_tsr_q, o_proc_q, o_defect_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_take    = in_i.valid && in_i.ready;

  // state reached by a command
  always_comb begin
    abort_branch = (state_q == ST_ABORTING) || (state_q == ST_ABORTED);
    cmd_next     = state_q;
    if (in_i.command == CMD_ABORT && !abort_branch) begin
      cmd_next = ST_ABORTING;
    end else if (in_i.command == CMD_STOP && !abort_branch &&
                 state_q != ST_STOPPING && state_q != ST_STOPPED &&
                 state_q != ST_CLEARING) begin
      cmd_next = ST_STOPPING;
    end else begin
      unique case (state_q)
        ST_STOPPED, ST_COMPLETE: begin
          if (in_i.command == CMD_RESET) cmd_next = ST_RESETTING;
        end
        ST_IDLE: begin
          if (in_i.command == CMD_START) cmd_next = ST_STARTING;
        end
        ST_EXECUTE: begin
          if (in_i.command == CMD_HOLD) cmd_next = ST_HOLDING;
          else if (in_i.command == CMD_SUSPEND) cmd_next = ST_SUSPENDING;
        end
        ST_HELD: begin
          if (in_i.command == CMD_UNHOLD) cmd_next = ST_UNHOLDING;
        end
        ST_SUSPENDED: begin
          if (in_i.command == CMD_UNSUSPEND) cmd_next = ST_UNSUSPENDING;
        end
        ST_ABORTED: begin
          if (in_i.command == CMD_CLEAR) cmd_next = ST_CLEARING;
        end
        default: ;
      endcase
    end
  end

  // state reached when an acting state completes
  always_comb begin
    unique case (state_q)
      ST_RESETTING:    done_next = ST_IDLE;
      ST_STARTING:     done_next = ST_EXECUTE;
      ST_HOLDING:      done_next = ST_HELD;
      ST_UNHOLDING:    done_next = ST_EXECUTE;
      ST_SUSPENDING:   done_next = ST_SUSPENDED;
      ST_UNSUSPENDING: done_next = ST_EXECUTE;
      ST_COMPLETING:   done_next = ST_COMPLETE;
      ST_STOPPING:     done_next = ST_STOPPED;
      ST_ABORTING:     done_next = ST_ABORTED;
      ST_CLEARING:     done_next = ST_STOPPED;
      default:         done_next = state_q;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    umode_d  = umode_q;
    proc_d   = proc_q;
    defect_d = defect_q;
    tis_d    = tis_q;
    tsr_d    = tsr_q;
    acc_d    = 1'b0;
    unique case (in_i.mode)
      KIND_COMMAND: begin
        if (cmd_next != state_q) begin
          state_d = cmd_next;
          tis_d   = '0;
          acc_d   = 1'b1;
          if (in_i.command == CMD_RESET) tsr_d = '0;
        end
      end
      KIND_STATE_DONE: begin
        if (done_next != state_q) begin
          state_d = done_next;
          tis_d   = '0;
          acc_d   = 1'b1;
        end
      end
      KIND_EXEC_DONE: begin
        if (state_q == ST_EXECUTE) begin
          state_d = ST_COMPLETING;
          tis_d   = '0;
          acc_d   = 1'b1;
        end
      end
      KIND_COUNT: begin
        if (state_q == ST_EXECUTE) begin
          proc_d = proc_q + CountW'(1);
          if (in_i.defective) defect_d = defect_q + CountW'(1);
          acc_d = 1'b1;
        end
      end
      KIND_SET_MODE: begin
        if (state_q == ST_STOPPED || state_q == ST_IDLE || state_q == ST_ABORTED) begin
          umode_d = in_i.new_unit_mode;
          acc_d   = 1'b1;
        end
      end
      KIND_TICK: begin
        tis_d = tis_q + CountW'(1);
        tsr_d = tsr_q + CountW'(1);
        acc_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
    end else if (speed_command_we_i) begin
      speed_q <= speed_command_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_STOPPED;
      umode_q  <= UnitModeReset;
      proc_q   <= '0;
      defect_q <= '0;
      tis_q    <= '0;
      tsr_q    <= '0;
    end else if (in_take) begin
      state_q  <= state_d;
      umode_q  <= umode_d;
      proc_q   <= proc_d;
      defect_q <= defect_d;
      tis_q    <= tis_d;
      tsr_q    <= tsr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // status word register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      o_acc_q    <= acc_d;
      o_state_q  <= state_d;
      o_acting_q <= is_acting_f(state_d);
      o_umode_q  <= umode_d;
      o_speed_q  <= (state_d == ST_EXECUTE) ? speed_q : '0;
      o_tis_q    <= tis_d;
      o_tsr_q    <= tsr_d;
      o_proc_q   <= proc_d;
      o_defect_q <= defect_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.accepted        = o_acc_q;
  assign out_o.cur_state       = o_state_q;
  assign out_o.is_acting       = o_acting_q;
  assign out_o.cur_unit_mode   = o_umode_q;
  assign out_o.speed_actual    = o_speed_q;
  assign out_o.state_time_ms   = o_tis_q;
  assign out_o.run_time_ms     = o_tsr_q;
  assign out_o.units_processed = o_proc_q;
  assign out_o.units_defective = o_defect_q;

  a_count_in_execute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && in_i.mode == KIND_COUNT && state_q == ST_EXECUTE
    |=> proc_q == $past(proc_q) + CountW'(1))
    else $error("unit count in execute not taken");

  a_state_entry_clears_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && state_d != state_q |=> tis_q == '0)
    else $error("state change did not clear time in state");

  a_speed_only_in_execute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.speed_actual != '0 |-> out_o.cur_state == ST_EXECUTE)
    else $error("nonzero speed outside execute");

  a_status_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> o_state_q == state_q && o_umode_q == umode_q && o_tsr_q == tsr_q)
    else $error("status word does not match machine state");

endmodule
